/* src/bppd_pkg.sv */
`timescale 1ns / 1ps
package bppd_pkg;

  // One pixel, also the input transaction payload
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  // One result transaction
  typedef struct packed {
    logic [2:0] pixel_row;
    logic [1:0] pixel_col;
    logic [1:0] pixel_code;
    logic [3:0] slot1_color;
    logic [3:0] slot2_color;
    logic [3:0] slot3_color;
    logic       block_done;
  } out_t;

  localparam logic [15:0] SUM_LIMIT = 16'hFFFF;

  // Fixed base colors
  function automatic in_t base_rgb(input logic [3:0] j);
    in_t c;
    begin
      case (j)
        4'd0:    c = '{8'h00, 8'h00, 8'h00};
        4'd1:    c = '{8'hFF, 8'hFF, 8'hFF};
        4'd2:    c = '{8'h68, 8'h37, 8'h2B};
        4'd3:    c = '{8'h70, 8'hA4, 8'hB2};
        4'd4:    c = '{8'h6F, 8'h3D, 8'h86};
        4'd5:    c = '{8'h58, 8'h8D, 8'h43};
        4'd6:    c = '{8'h35, 8'h28, 8'h79};
        4'd7:    c = '{8'hB8, 8'hC7, 8'h6F};
        4'd8:    c = '{8'h6F, 8'h4F, 8'h25};
        4'd9:    c = '{8'h43, 8'h39, 8'h00};
        4'd10:   c = '{8'h9A, 8'h67, 8'h59};
        4'd11:   c = '{8'h44, 8'h44, 8'h44};
        4'd12:   c = '{8'h6C, 8'h6C, 8'h6C};
        4'd13:   c = '{8'h9A, 8'hD2, 8'h84};
        4'd14:   c = '{8'h6C, 8'h5E, 8'hB5};
        default: c = '{8'h95, 8'h95, 8'h95};
      endcase
      return c;
    end
  endfunction

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // L1 RGB distance, up to 765
  function automatic logic [9:0] l1(input in_t a, input in_t b);
    return 10'(absdiff(a.red, b.red)) + 10'(absdiff(a.green, b.green))
         + 10'(absdiff(a.blue, b.blue));
  endfunction

  // Nearest of four palette colors, lowest slot wins ties
  function automatic logic [1:0] nearest(input in_t p, input in_t c0, input in_t c1,
                                         input in_t c2, input in_t c3);
    logic [9:0] bd, e1, e2, e3;
    logic [1:0] best;
    begin
      bd = l1(p, c0);
      best = 2'd0;
      e1 = l1(p, c1);
      e2 = l1(p, c2);
      e3 = l1(p, c3);
      if (e1 < bd) begin
        bd = e1;
        best = 2'd1;
      end
      if (e2 < bd) begin
        bd = e2;
        best = 2'd2;
      end
      if (e3 < bd) begin
        best = 2'd3;
      end
      return best;
    end
  endfunction

  // floor((d*2^sh + a - m) / 2^sh) clamped to 0..255
  function automatic logic [7:0] spread_ch(input logic [7:0] a, input logic [7:0] m,
                                           input logic [7:0] d, input logic [1:0] sh);
    logic signed [11:0] k;
    logic signed [11:0] q;
    begin
      k = ($signed({4'b0, d}) <<< sh) + $signed({4'b0, a}) - $signed({4'b0, m});
      q = k >>> sh;
      if (q < 0) return 8'd0;
      else if (q > 12'sd255) return 8'd255;
      else return q[7:0];
    end
  endfunction

  function automatic in_t spread_px(input in_t dst, input in_t src, input in_t m,
                                    input logic [1:0] sh);
    in_t r;
    begin
      r.red   = spread_ch(src.red,   m.red,   dst.red,   sh);
      r.green = spread_ch(src.green, m.green, dst.green, sh);
      r.blue  = spread_ch(src.blue,  m.blue,  dst.blue,  sh);
      return r;
    end
  endfunction

endpackage

/* src/block_palette_pick_and_dither.sv */
`timescale 1ns / 1ps
// Takes the pixels of a BLOCK_ROWS x BLOCK_COLS block, one per start cycle, in raster
// order, then emits one palette code per pixel in raster order, one per cycle on
// out_valid; the receiver cannot stall. A pixel is taken in the cycle it is offered
// while a block buffer is free: two buffers let the next block load while the back
// end works. The back end processes one block at a time, with its single distance-
// accumulate unit sweeping the pixel memory.
module block_palette_pick_and_dither #(
  parameter int BLOCK_ROWS  = 8,
  parameter int BLOCK_COLS  = 4,
  parameter int BASE_COLORS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bppd_pkg::in_t  in_data,
  output logic           out_valid,
  output bppd_pkg::out_t out_data
);
  import bppd_pkg::*;

  localparam int NPIX = BLOCK_ROWS * BLOCK_COLS;
  localparam int AW   = $clog2(NPIX) + 1;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [23:0]   wr_data, rd_data;
  logic          blk_avail, blk_release;

  bppd_front #(.NPIX(NPIX)) u_front (
    .clk, .rst_n, .start, .busy, .in_data,
    .wr_en, .wr_addr, .wr_data, .blk_avail, .blk_release
  );

  // two block buffers of pixels
  bppd_ram #(.WIDTH(24), .DEPTH(1 << AW)) u_pix_ram (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rd_data)
  );

  bppd_back #(
    .BLOCK_ROWS(BLOCK_ROWS), .BLOCK_COLS(BLOCK_COLS), .BASE_COLORS(BASE_COLORS)
  ) u_back (
    .clk, .rst_n, .blk_avail, .blk_release, .rd_addr, .rd_data, .out_valid, .out_data
  );

  a_release_done: assert property (@(posedge clk) disable iff (!rst_n)
    blk_release |=> out_valid && out_data.block_done)
    else $error("block release without final result");

  a_busy_queued: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> blk_avail)
    else $error("busy with empty block queue");

  a_gap_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.block_done |=> !out_valid)
    else $error("result right after block end");
endmodule

/* src/bppd_ram.sv */
`timescale 1ns / 1ps
module bppd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/bppd_front.sv */
`timescale 1ns / 1ps
module bppd_front #(
  parameter int NPIX = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  bppd_pkg::in_t            in_data,
  output logic                     wr_en,
  output logic [$clog2(NPIX):0]    wr_addr,
  output logic [23:0]              wr_data,
  output logic                     blk_avail,
  input  logic                     blk_release
);
  import bppd_pkg::*;

  localparam int IW = $clog2(NPIX);

  logic [IW-1:0] cnt_r;
  logic          wb_r;
  logic [1:0]    qcnt_r;
  logic          acc;
  logic          last;

  // two bank slots form the queue toward the back end
  assign busy      = (qcnt_r == 2'd2);
  assign blk_avail = (qcnt_r != 2'd0);
  assign acc       = start && !busy;
  assign last      = (cnt_r == IW'(NPIX - 1));

  assign wr_en   = acc;
  assign wr_addr = {wb_r, cnt_r};
  assign wr_data = in_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      wb_r   <= 1'b0;
      qcnt_r <= 2'd0;
    end else begin
      if (acc) begin
        cnt_r <= last ? '0 : cnt_r + 1'b1;
        if (last) begin
          wb_r <= ~wb_r;
        end
      end
      // queue occupancy
      if ((acc && last) && !blk_release) begin
        qcnt_r <= qcnt_r + 2'd1;
      end else if (!(acc && last) && blk_release) begin
        qcnt_r <= qcnt_r - 2'd1;
      end
    end
  end
endmodule

/* src/bppd_back.sv */
`timescale 1ns / 1ps
module bppd_back #(
  parameter int BLOCK_ROWS  = 8,
  parameter int BLOCK_COLS  = 4,
  parameter int BASE_COLORS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                blk_avail,
  output logic                                blk_release,
  output logic [$clog2(BLOCK_ROWS*BLOCK_COLS):0] rd_addr,
  input  logic [23:0]                         rd_data,
  output logic                                out_valid,
  output bppd_pkg::out_t                      out_data
);
  import bppd_pkg::*;

  localparam int NPIX = BLOCK_ROWS * BLOCK_COLS;
  localparam int IW   = $clog2(NPIX);
  localparam int KW   = IW + 1;
  localparam int QR   = BLOCK_ROWS / 2;
  localparam int QC   = BLOCK_COLS / 2;
  localparam int QYW  = (QR > 1) ? $clog2(QR) : 1;
  localparam int QXW  = (QC > 1) ? $clog2(QC) : 1;
  localparam int RW   = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
  localparam int CW   = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;
  localparam int SW0  = $clog2(NPIX * 765 + 1);
  localparam int SW   = (SW0 > 16) ? SW0 : 16;
  localparam int LASTC = (BASE_COLORS > 16) ? 15 : BASE_COLORS - 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_QLD  = 3'd4;
  localparam logic [2:0] S_QST  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]     state_r;
  logic           iss_r, vd_r, ve_r, rb_r;
  logic [KW-1:0]  k_r;
  logic [IW-1:0]  kd_r;
  logic [9:0]     emin_r;
  logic [SW-1:0]  sum_r, best_r;
  logic [3:0]     col_r, jbest_r;
  logic [1:0]     pick_r;
  logic [3:0]     pal_r [4];
  logic [9:0]     nd_r [NPIX];
  logic [1:0]     code_r [NPIX];
  in_t            p_r [4];
  logic [2:0]     step_r;
  logic [1:0]     cs_r;
  logic [QYW-1:0] qy_r;
  logic [QXW-1:0] qx_r;
  logic [RW-1:0]  erow_r;
  logic [CW-1:0]  ecol_r;
  logic           out_valid_r;
  out_t           out_data_r;

  logic [IW-1:0]  qidx [4];
  logic [IW-1:0]  base_idx;
  logic [9:0]     e;
  in_t            pix;
  in_t            palc [4];
  logic           scanning, drained, last_k, better;
  logic [SW-1:0]  nbest;
  logic [3:0]     njbest;
  logic [1:0]     ncode;

  // quad member addresses, mapped in order TL, BR, TR, BL
  assign base_idx = IW'((32'(qy_r) * 2) * BLOCK_COLS + 32'(qx_r) * 2);
  assign qidx[0]  = base_idx;
  assign qidx[1]  = IW'(32'(base_idx) + BLOCK_COLS + 1);
  assign qidx[2]  = IW'(32'(base_idx) + 1);
  assign qidx[3]  = IW'(32'(base_idx) + BLOCK_COLS);

  assign rd_addr = {rb_r, (state_r == S_QLD) ? qidx[k_r[1:0]] : k_r[IW-1:0]};
  assign pix     = rd_data;
  assign e       = l1(pix, base_rgb(col_r));

  assign palc[0] = base_rgb(4'd0);
  assign palc[1] = base_rgb(pal_r[1]);
  assign palc[2] = base_rgb(pal_r[2]);
  assign palc[3] = base_rgb(pal_r[3]);

  assign scanning = (state_r == S_INIT) || (state_r == S_SUM) || (state_r == S_UPD)
                 || (state_r == S_QLD);
  assign drained  = !iss_r && !vd_r && !ve_r;
  assign last_k   = (state_r == S_QLD) ? (k_r == KW'(3)) : (k_r == KW'(NPIX - 1));
  assign better   = (sum_r < best_r);
  assign nbest    = better ? sum_r : best_r;
  assign njbest   = better ? col_r : jbest_r;

  // slot decision for the current mapping step
  always_comb begin
    case (step_r)
      3'd0:    ncode = nearest(p_r[0], palc[0], palc[1], palc[2], palc[3]);
      3'd2:    ncode = nearest(p_r[1], palc[0], palc[1], palc[2], palc[3]);
      3'd4:    ncode = nearest(p_r[2], palc[0], palc[1], palc[2], palc[3]);
      default: ncode = nearest(p_r[3], palc[0], palc[1], palc[2], palc[3]);
    endcase
  end

  assign blk_release = (state_r == S_EMIT) && (k_r == KW'(NPIX - 1));
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= 1'b0;
      vd_r        <= 1'b0;
      ve_r        <= 1'b0;
      rb_r        <= 1'b0;
      k_r         <= '0;
      col_r       <= '0;
      jbest_r     <= '0;
      pick_r      <= 2'd1;
      step_r      <= '0;
      qy_r        <= '0;
      qx_r        <= '0;
      erow_r      <= '0;
      ecol_r      <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < 4; s++) pal_r[s] <= '0;
    end else begin
      vd_r        <= iss_r && scanning;
      ve_r        <= vd_r && (state_r == S_SUM);
      out_valid_r <= (state_r == S_EMIT);
      if (iss_r && scanning) begin
        k_r <= k_r + 1'b1;
        if (last_k) iss_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (blk_avail) begin
            state_r <= S_INIT;
            col_r   <= 4'd0;
            k_r     <= '0;
            iss_r   <= 1'b1;
          end
        end
        S_INIT: begin
          if (drained) begin
            state_r <= S_SUM;
            col_r   <= 4'd1;
            jbest_r <= '0;
            pick_r  <= 2'd1;
            k_r     <= '0;
            iss_r   <= 1'b1;
          end
        end
        S_SUM: begin
          if (drained) begin
            k_r   <= '0;
            iss_r <= 1'b1;
            if (col_r == 4'(LASTC)) begin
              pal_r[pick_r] <= njbest;
              col_r         <= njbest;
              state_r       <= S_UPD;
            end else begin
              col_r   <= col_r + 4'd1;
              jbest_r <= njbest;
            end
          end
        end
        S_UPD: begin
          if (drained) begin
            k_r   <= '0;
            iss_r <= 1'b1;
            if (pick_r == 2'd3) begin
              state_r <= S_QLD;
              qy_r    <= '0;
              qx_r    <= '0;
            end else begin
              state_r <= S_SUM;
              pick_r  <= pick_r + 2'd1;
              col_r   <= 4'd1;
              jbest_r <= '0;
            end
          end
        end
        S_QLD: begin
          if (drained) begin
            state_r <= S_QST;
            step_r  <= '0;
          end
        end
        S_QST: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd6) begin
            if (qx_r == QXW'(QC - 1)) begin
              qx_r <= '0;
              if (qy_r == QYW'(QR - 1)) begin
                state_r <= S_EMIT;
                k_r     <= '0;
                erow_r  <= '0;
                ecol_r  <= '0;
              end else begin
                qy_r    <= qy_r + 1'b1;
                state_r <= S_QLD;
                k_r     <= '0;
                iss_r   <= 1'b1;
              end
            end else begin
              qx_r    <= qx_r + 1'b1;
              state_r <= S_QLD;
              k_r     <= '0;
              iss_r   <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          k_r <= k_r + 1'b1;
          if (ecol_r == CW'(BLOCK_COLS - 1)) begin
            ecol_r <= '0;
            erow_r <= erow_r + 1'b1;
          end else begin
            ecol_r <= ecol_r + 1'b1;
          end
          if (blk_release) begin
            state_r <= S_IDLE;
            rb_r    <= ~rb_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath: distances, sums, quad pixels, codes, result register
  always_ff @(posedge clk) begin
    kd_r   <= k_r[IW-1:0];
    emin_r <= (e < nd_r[kd_r]) ? e : nd_r[kd_r];
    if (ve_r) sum_r <= sum_r + SW'(emin_r);
    if (state_r == S_INIT && vd_r) nd_r[kd_r] <= e;
    if (state_r == S_UPD && vd_r && (e < nd_r[kd_r])) nd_r[kd_r] <= e;
    if ((state_r == S_INIT || state_r == S_UPD) && drained) begin
      sum_r  <= '0;
      best_r <= SW'(SUM_LIMIT);
    end
    if (state_r == S_SUM && drained) begin
      sum_r  <= '0;
      best_r <= nbest;
    end
    if (state_r == S_QLD && vd_r) p_r[kd_r[1:0]] <= pix;
    // unmapped pixels of odd-sized blocks keep code 0
    if (state_r == S_UPD && drained && pick_r == 2'd3) begin
      for (int i = 0; i < NPIX; i++) code_r[i] <= 2'd0;
    end
    if (state_r == S_QST) begin
      case (step_r)
        3'd0: begin
          code_r[qidx[0]] <= ncode;
          cs_r            <= ncode;
        end
        3'd1: begin
          p_r[1] <= spread_px(p_r[1], p_r[0], palc[cs_r], 2'd1);
          p_r[2] <= spread_px(p_r[2], p_r[0], palc[cs_r], 2'd2);
          p_r[3] <= spread_px(p_r[3], p_r[0], palc[cs_r], 2'd2);
        end
        3'd2: begin
          code_r[qidx[1]] <= ncode;
          cs_r            <= ncode;
        end
        3'd3: begin
          p_r[2] <= spread_px(p_r[2], p_r[1], palc[cs_r], 2'd1);
          p_r[3] <= spread_px(p_r[3], p_r[1], palc[cs_r], 2'd1);
        end
        3'd4: begin
          code_r[qidx[2]] <= ncode;
          cs_r            <= ncode;
        end
        3'd5: begin
          p_r[3] <= spread_px(p_r[3], p_r[2], palc[cs_r], 2'd0);
        end
        default: begin
          code_r[qidx[3]] <= ncode;
        end
      endcase
    end
    out_data_r.pixel_row   <= 3'(erow_r);
    out_data_r.pixel_col   <= 2'(ecol_r);
    out_data_r.pixel_code  <= code_r[k_r[IW-1:0]];
    out_data_r.slot1_color <= pal_r[1];
    out_data_r.slot2_color <= pal_r[2];
    out_data_r.slot3_color <= pal_r[3];
    out_data_r.block_done  <= (k_r == KW'(NPIX - 1));
  end
endmodule

/* verif/block_palette_pick_and_dither_test.sv */
`timescale 1ns / 1ps
module block_palette_pick_and_dither_test;
  import bppd_pkg::*;

  localparam int NPIX = 32;
  localparam int DIRECTED_ROWS = 12;
  localparam int RANDOM_ITEMS = 320;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;

  block_palette_pick_and_dither i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Predictor state: one block of pixels being gathered
  logic [7:0] blk_px [NPIX][3];
  int unsigned px_count = 0;
  out_t expected_codes [$];
  int errors = 0;
  longint cycle_count = 0;

  // Directed stimulus; a row holds one color, and the first rows each fill a whole block
  typedef struct {
    logic [7:0] r, g, b;
    logic       has_exp;
    logic [3:0] s1, s2, s3;
    logic [1:0] code;
  } dir_row_t;
  dir_row_t dir_tab [DIRECTED_ROWS];

  function automatic logic [7:0] pal_ch(input logic [3:0] idx, input int c);
    logic [7:0] v [16][3];
    v = '{'{8'h00,8'h00,8'h00}, '{8'hFF,8'hFF,8'hFF}, '{8'h68,8'h37,8'h2B},
          '{8'h70,8'hA4,8'hB2}, '{8'h6F,8'h3D,8'h86}, '{8'h58,8'h8D,8'h43},
          '{8'h35,8'h28,8'h79}, '{8'hB8,8'hC7,8'h6F}, '{8'h6F,8'h4F,8'h25},
          '{8'h43,8'h39,8'h00}, '{8'h9A,8'h67,8'h59}, '{8'h44,8'h44,8'h44},
          '{8'h6C,8'h6C,8'h6C}, '{8'h9A,8'hD2,8'h84}, '{8'h6C,8'h5E,8'hB5},
          '{8'h95,8'h95,8'h95}};
    return v[idx][c];
  endfunction

  function automatic int dist_l1(input logic [7:0] p [3], input logic [3:0] idx);
    int s;
    s = 0;
    for (int c = 0; c < 3; c++) begin
      s += (p[c] > pal_ch(idx, c)) ? p[c] - pal_ch(idx, c) : pal_ch(idx, c) - p[c];
    end
    return s;
  endfunction

  function automatic logic [7:0] diffuse(input int a, input int m, input int d, input int sh);
    int k, q;
    k = (d << sh) + a - m;
    q = k >>> sh;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // Palette pick, error-diffused mapping, then queue 32 expected codes
  task automatic predict_block();
    logic [3:0] pal [4];
    int near_d [NPIX];
    logic [1:0] codes [NPIX];
    logic [7:0] q [4][3];
    int idx [4];
    int best_sum, best_j, sum, e, bd;
    logic [1:0] slot;
    out_t o;
    pal[0] = 4'd0;
    for (int k = 0; k < NPIX; k++) near_d[k] = dist_l1(blk_px[k], 4'd0);
    for (int i = 1; i < 4; i++) begin
      best_sum = 65535;
      best_j = 0;
      for (int j = 1; j < 16; j++) begin
        sum = 0;
        for (int k = 0; k < NPIX; k++) begin
          e = dist_l1(blk_px[k], 4'(j));
          sum += (e < near_d[k]) ? e : near_d[k];
        end
        if (sum < best_sum) begin
          best_sum = sum;
          best_j = j;
        end
      end
      pal[i] = 4'(best_j);
      for (int k = 0; k < NPIX; k++) begin
        e = dist_l1(blk_px[k], pal[i]);
        if (e < near_d[k]) near_d[k] = e;
      end
    end
    // quads in order top-left, bottom-right, top-right, bottom-left
    for (int y = 0; y < 8; y += 2) begin
      for (int x = 0; x < 4; x += 2) begin
        idx = '{y*4 + x, (y+1)*4 + x + 1, y*4 + x + 1, (y+1)*4 + x};
        for (int n = 0; n < 4; n++) q[n] = blk_px[idx[n]];
        for (int n = 0; n < 4; n++) begin
          bd = dist_l1(q[n], pal[0]);
          slot = 2'd0;
          for (int s = 1; s < 4; s++) begin
            e = dist_l1(q[n], pal[s]);
            if (e < bd) begin
              bd = e;
              slot = 2'(s);
            end
          end
          codes[idx[n]] = slot;
          for (int c = 0; c < 3; c++) begin
            if (n == 0) begin
              q[1][c] = diffuse(q[0][c], pal_ch(pal[slot], c), q[1][c], 1);
              q[2][c] = diffuse(q[0][c], pal_ch(pal[slot], c), q[2][c], 2);
              q[3][c] = diffuse(q[0][c], pal_ch(pal[slot], c), q[3][c], 2);
            end else if (n == 1) begin
              q[2][c] = diffuse(q[1][c], pal_ch(pal[slot], c), q[2][c], 1);
              q[3][c] = diffuse(q[1][c], pal_ch(pal[slot], c), q[3][c], 1);
            end else if (n == 2) begin
              q[3][c] = diffuse(q[2][c], pal_ch(pal[slot], c), q[3][c], 0);
            end
          end
        end
      end
    end
    for (int k = 0; k < NPIX; k++) begin
      o.pixel_row = 3'(k / 4);
      o.pixel_col = 2'(k % 4);
      o.pixel_code = codes[k];
      o.slot1_color = pal[1];
      o.slot2_color = pal[2];
      o.slot3_color = pal[3];
      o.block_done = (k == NPIX - 1);
      expected_codes.push_back(o);
    end
  endtask

  task automatic record_pixel(input in_t p);
    blk_px[px_count] = '{p.red, p.green, p.blue};
    px_count++;
    if (px_count == NPIX) begin
      px_count = 0;
      predict_block();
    end
  endtask

  // Offer one pixel and hold start until the transaction is taken
  logic idle_on = 1'b1;
  task automatic send_pixel(input in_t p);
    if (idle_on) begin
      while ($urandom_range(99) < 7) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    record_pixel(p);
  endtask

  // Result checking
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        want = expected_codes.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Typed expectation for uniform blocks, read off the palette at a glance
  task automatic check_uniform_palette(input dir_row_t r);
    out_t head;
    head = expected_codes[expected_codes.size() - NPIX];
    if (r.has_exp && (head.slot1_color !== r.s1 || head.slot2_color !== r.s2 ||
        head.slot3_color !== r.s3 || head.pixel_code !== r.code)) begin
      $display("%0t: table mismatch expected %h %h %h code %0d actual %h %h %h code %0d",
               $time, r.s1, r.s2, r.s3, r.code, head.slot1_color, head.slot2_color,
               head.slot3_color, head.pixel_code);
      errors++;
    end
  endtask

  initial begin
    in_t p;
    int blocks;
    // black, white, base colors: exact matches, later picks tie on zero sums
    dir_tab[0] = '{8'h00, 8'h00, 8'h00, 1'b1, 4'd1, 4'd1, 4'd1, 2'd0};
    dir_tab[1] = '{8'hFF, 8'hFF, 8'hFF, 1'b1, 4'd1, 4'd1, 4'd1, 2'd1};
    dir_tab[2] = '{8'h95, 8'h95, 8'h95, 1'b1, 4'd15, 4'd1, 4'd1, 2'd1};
    dir_tab[3] = '{8'hFF, 8'h00, 8'h00, 1'b0, 4'd0, 4'd0, 4'd0, 2'd0};
    dir_tab[4] = '{8'h00, 8'hFF, 8'h00, 1'b0, 4'd0, 4'd0, 4'd0, 2'd0};
    dir_tab[5] = '{8'h00, 8'h00, 8'hFF, 1'b0, 4'd0, 4'd0, 4'd0, 2'd0};
    dir_tab[6] = '{8'hAA, 8'h55, 8'hAA, 1'b0, 4'd0, 4'd0, 4'd0, 2'd0};
    dir_tab[7] = '{8'h55, 8'hAA, 8'h55, 1'b0, 4'd0, 4'd0, 4'd0, 2'd0};
    dir_tab[8] = '{8'h01, 8'h01, 8'h01, 1'b0, 4'd0, 4'd0, 4'd0, 2'd0};
    dir_tab[9] = '{8'hFE, 8'hFE, 8'hFE, 1'b0, 4'd0, 4'd0, 4'd0, 2'd0};
    dir_tab[10] = '{8'h80, 8'h80, 8'h80, 1'b0, 4'd0, 4'd0, 4'd0, 2'd0};
    dir_tab[11] = '{8'h7F, 8'h7F, 8'h7F, 1'b0, 4'd0, 4'd0, 4'd0, 2'd0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the first rows fill a block each; the rest alternate per pixel
    // (checkerboard-like blocks drive the clamp at both ends)
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < NPIX; k++) begin
        send_pixel('{dir_tab[r].r, dir_tab[r].g, dir_tab[r].b});
      end
      check_uniform_palette(dir_tab[r]);
    end
    for (int k = 0; k < NPIX; k++) begin
      p = '{dir_tab[3 + (k % 9)].r, dir_tab[3 + (k % 9)].g, dir_tab[3 + (k % 9)].b};
      send_pixel(p);
    end
    start <= 1'b0;

    // Hold off until the block drains
    while (expected_codes.size() != 0) @(posedge clk);

    // Random blocks in mixed content styles, with no idling for the first two
    blocks = (RANDOM_ITEMS + NPIX - 1) / NPIX;
    for (int b = 0; b < blocks; b++) begin
      idle_on = (b >= 2);
      for (int k = 0; k < NPIX; k++) begin
        case (b % 3)
          0: p = in_t'(24'($urandom));
          1: p = in_t'({8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255))} | ($urandom_range(1) ? 24'hF0F0F0 : 24'h0));
          default: p = ($urandom_range(1)) ? in_t'(24'hFFFFFF)
                                           : in_t'(24'($urandom) & 24'h0F0F0F);
        endcase
        send_pixel(p);
      end
    end
    start <= 1'b0;

    while (expected_codes.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
